[rtl/rrpm_pkg.sv]
// Package for the round-robin polling master: shared types, codes and helpers.
// Used by rrpm_step and round_robin_poll_master_retry_core; depends on nothing.
`default_nettype none
package rrpm_pkg;

    // Event codes carried in the command field of an input beat.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_RETRY   = 3'd1;
    localparam logic [2:0] REG_ADDR0   = 3'd2;
    localparam logic [2:0] REG_ADDR1   = 3'd3;
    localparam logic [2:0] REG_ADDR2   = 3'd4;
    localparam logic [2:0] REG_ADDR3   = 3'd5;

    // Phase codes as reported in the result beat.
    localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CODE_WAIT = 2'd1;
    localparam logic [1:0] PHASE_CODE_FAIL = 2'd2;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_FAIL = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  slave_index;
        logic [3:0]  retries_used;
        logic [15:0] ticks_waited;
    } state_t;

    typedef struct packed {
        logic [15:0]     timeout_ticks;
        logic [3:0]      retry_limit;
        logic [3:0][7:0] slave_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0] phase_now;
        logic       link_failed;
        logic       cycle_done;
        logic [1:0] reply_slave;
        logic       reply_taken;
        logic [7:0] request_address;
        logic       send_request;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE: code = PHASE_CODE_IDLE;
            PH_WAIT: code = PHASE_CODE_WAIT;
            PH_FAIL: code = PHASE_CODE_FAIL;
            default: code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[rtl/round_robin_poll_master_retry_core.sv]
// Top level of the round-robin polling master with reply timeout and retry.
// Depends on rrpm_pkg and rrpm_step.
//
// Channel   Direction  Width  Contents
// s_*       in         8      event beat: command, reply_ok
// m_*       out        16     result beat, one for every event beat
// cfg_*     in         3+16   register writes, no read-back
//
// Each event beat is applied to the state registers in the cycle it is
// accepted, and its result beat appears on m_* on the next cycle, so the
// block sustains one beat per clock. The result register is the only stage;
// a new beat is taken whenever that register is empty or is being emptied.
// A stall on m_tready holds the result and drops s_tready in the same cycle.
// Reset clears the phase to idle, the counters to zero and the registers to
// their default values (timeout 100, three retries, addresses 0 to 3).
`default_nettype none
module round_robin_poll_master_retry_core #(
    parameter int NUM_SLAVES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Event beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] command, [2] reply_ok, [7:3] zero
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] send_request, [8:1] request_address,
                                   // [9] reply_taken, [11:10] reply_slave,
                                   // [12] cycle_done, [13] link_failed,
                                   // [15:14] phase_now
    // Register writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rrpm_pkg::cfg_t    cfg_reg;
    rrpm_pkg::state_t  st_reg;
    rrpm_pkg::state_t  st_next;
    rrpm_pkg::result_t res_reg;
    rrpm_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              in_fire;

    // The result register can take a new beat when it is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Configuration registers; writes to indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks    <= 16'd100;
            cfg_reg.retry_limit      <= 4'd3;
            cfg_reg.slave_address[0] <= 8'd0;
            cfg_reg.slave_address[1] <= 8'd1;
            cfg_reg.slave_address[2] <= 8'd2;
            cfg_reg.slave_address[3] <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrpm_pkg::REG_TIMEOUT: cfg_reg.timeout_ticks    <= cfg_data;
                rrpm_pkg::REG_RETRY:   cfg_reg.retry_limit      <= cfg_data[3:0];
                rrpm_pkg::REG_ADDR0:   cfg_reg.slave_address[0] <= cfg_data[7:0];
                rrpm_pkg::REG_ADDR1:   cfg_reg.slave_address[1] <= cfg_data[7:0];
                rrpm_pkg::REG_ADDR2:   cfg_reg.slave_address[2] <= cfg_data[7:0];
                rrpm_pkg::REG_ADDR3:   cfg_reg.slave_address[3] <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // All event handling lives in the step logic; it sees the current state
    // and the beat being accepted.
    rrpm_step #(
        .NUM_SLAVES (NUM_SLAVES)
    ) u_step (
        .st       (st_reg),
        .cfg      (cfg_reg),
        .command  (s_tdata[1:0]),
        .reply_ok (s_tdata[2]),
        .st_next  (st_next),
        .res      (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase        <= rrpm_pkg::PH_IDLE;
            st_reg.slave_index  <= 2'd0;
            st_reg.retries_used <= 4'd0;
            st_reg.ticks_waited <= 16'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                st_reg <= st_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.phase_now, res_reg.link_failed, res_reg.cycle_done,
                       res_reg.reply_slave, res_reg.reply_taken,
                       res_reg.request_address, res_reg.send_request};

    // A start beat always leaves a request to slave 0 and the waiting phase.
    a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tdata[1:0] == rrpm_pkg::CMD_START) |=>
        (m_tvalid && res_reg.send_request
         && res_reg.request_address == cfg_reg.slave_address[0]
         && res_reg.phase_now == rrpm_pkg::PHASE_CODE_WAIT))
        else $error("start beat did not produce a request to the first slave");

    // Giving up on the link never goes together with a resend.
    a_fail_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.link_failed) |->
        (!res_reg.send_request && res_reg.phase_now == rrpm_pkg::PHASE_CODE_FAIL))
        else $error("link failure reported with a request or wrong phase");

    // The end of a round comes only with the last slave's reply.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.cycle_done) |->
        (res_reg.reply_taken && res_reg.reply_slave == 2'(NUM_SLAVES - 1)
         && res_reg.phase_now == rrpm_pkg::PHASE_CODE_IDLE))
        else $error("cycle done without the last slave's reply");

    // The failed phase is left only through a start beat.
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == rrpm_pkg::PH_FAIL
         && !(in_fire && s_tdata[1:0] == rrpm_pkg::CMD_START)) |=>
        (st_reg.phase == rrpm_pkg::PH_FAIL))
        else $error("failed phase left without a start beat");

    // The input side is held off only by a stalled result.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("event beat refused without an output stall");

endmodule
`default_nettype wire

[rtl/rrpm_step.sv]
// Next-state and result logic of the polling master for one event.
// Purely combinational; depends on rrpm_pkg.
`default_nettype none
module rrpm_step #(
    parameter int NUM_SLAVES = 4
) (
    input  rrpm_pkg::state_t  st,
    input  rrpm_pkg::cfg_t    cfg,
    input  logic [1:0]        command,
    input  logic              reply_ok,
    output rrpm_pkg::state_t  st_next,
    output rrpm_pkg::result_t res
);

    localparam logic [2:0] SLAVE_COUNT = 3'(NUM_SLAVES);

    logic [15:0] ticks_sat;
    logic        error;
    logic [2:0]  index_plus_one;

    assign ticks_sat = (st.ticks_waited != rrpm_pkg::TICKS_MAX) ?
                       st.ticks_waited + 16'd1 : st.ticks_waited;
    assign index_plus_one = {1'b0, st.slave_index} + 3'd1;

    always_comb
    begin
        st_next = st;
        res     = '0;
        error   = 1'b0;

        case (command)
            rrpm_pkg::CMD_START:
            begin
                st_next.slave_index  = 2'd0;
                st_next.retries_used = 4'd0;
                st_next.phase        = rrpm_pkg::PH_WAIT;
                st_next.ticks_waited = 16'd0;
                res.send_request     = 1'b1;
                res.request_address  = cfg.slave_address[0];
            end
            rrpm_pkg::CMD_TICK:
            begin
                if (st.phase == rrpm_pkg::PH_WAIT)
                begin
                    st_next.ticks_waited = ticks_sat;
                    error = (ticks_sat > cfg.timeout_ticks);
                end
            end
            rrpm_pkg::CMD_REPLY:
            begin
                if (st.phase == rrpm_pkg::PH_WAIT)
                begin
                    if (reply_ok)
                    begin
                        res.reply_taken = 1'b1;
                        res.reply_slave = st.slave_index;
                        if (index_plus_one >= SLAVE_COUNT)
                        begin
                            // Last slave answered: the round is complete.
                            st_next.slave_index  = 2'd0;
                            st_next.ticks_waited = 16'd0;
                            st_next.phase        = rrpm_pkg::PH_IDLE;
                            res.cycle_done       = 1'b1;
                        end
                        else
                        begin
                            st_next.slave_index  = index_plus_one[1:0];
                            st_next.retries_used = 4'd0;
                            st_next.ticks_waited = 16'd0;
                            res.send_request     = 1'b1;
                            res.request_address  = cfg.slave_address[index_plus_one[1:0]];
                        end
                    end
                    else
                    begin
                        error = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A timeout or a bad reply either resends or gives up on the link.
        if (error)
        begin
            if (st.retries_used < cfg.retry_limit)
            begin
                st_next.retries_used = st.retries_used + 4'd1;
                st_next.ticks_waited = 16'd0;
                res.send_request     = 1'b1;
                res.request_address  = cfg.slave_address[st.slave_index];
            end
            else
            begin
                st_next.phase   = rrpm_pkg::PH_FAIL;
                res.link_failed = 1'b1;
            end
        end

        res.phase_now = rrpm_pkg::phase_code(st_next.phase);
    end

endmodule
`default_nettype wire

[tb/poll_master_checker.sv]
// Checker for the round-robin polling master: watches the event, result and register
// channels, predicts each result beat and compares it field by field.
// Depends on rrpm_pkg for the event, register and phase codes and the result layout.
`timescale 1ns / 1ps
module poll_master_checker #(
    parameter int NUM_SLAVES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [1:0] command, [2] reply_ok, [7:3] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [0] send_request, [8:1] request_address,
                                    // [9] reply_taken, [11:10] reply_slave,
                                    // [12] cycle_done, [13] link_failed,
                                    // [15:14] phase_now
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pending,
    output logic [1:0]  phase_hint,
    output int          fail_count
);

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  slave;
        logic [3:0]  tries;
        logic [15:0] ticks;
    } poll_state_t;

    logic [15:0]         timeout_q;
    logic [3:0]          retry_q;
    logic [7:0]          addr_q [4];
    poll_state_t         st;
    rrpm_pkg::result_t   expected_q [$];
    int                  outstanding = 0;
    int                  errors = 0;

    assign pending    = outstanding;
    assign fail_count = errors;
    assign phase_hint = st.phase;

    // Applies one event to a copy of the master state and returns the result beat.
    function automatic rrpm_pkg::result_t poll_event(input logic [1:0] cmd,
                                                     input logic ok,
                                                     input poll_state_t cur,
                                                     output poll_state_t nxt);
        rrpm_pkg::result_t r;
        logic              fault;
        r     = '0;
        nxt   = cur;
        fault = 1'b0;
        if (cmd == rrpm_pkg::CMD_START) begin
            nxt.slave          = '0;
            nxt.tries          = '0;
            nxt.ticks          = '0;
            nxt.phase          = rrpm_pkg::PHASE_CODE_WAIT;
            r.send_request     = 1'b1;
            r.request_address  = addr_q[0];
        end else if (cmd == rrpm_pkg::CMD_TICK && cur.phase == rrpm_pkg::PHASE_CODE_WAIT) begin
            if (cur.ticks != rrpm_pkg::TICKS_MAX)
                nxt.ticks = cur.ticks + 16'd1;
            fault = (nxt.ticks > timeout_q);
        end else if (cmd == rrpm_pkg::CMD_REPLY
                     && cur.phase == rrpm_pkg::PHASE_CODE_WAIT) begin
            if (!ok) begin
                fault = 1'b1;
            end else begin
                r.reply_taken = 1'b1;
                r.reply_slave = cur.slave;
                if (int'(cur.slave) + 1 >= NUM_SLAVES) begin
                    nxt.slave    = '0;
                    nxt.ticks    = '0;
                    nxt.phase    = rrpm_pkg::PHASE_CODE_IDLE;
                    r.cycle_done = 1'b1;
                end else begin
                    nxt.slave         = cur.slave + 2'd1;
                    nxt.tries         = '0;
                    nxt.ticks         = '0;
                    r.send_request    = 1'b1;
                    r.request_address = addr_q[nxt.slave];
                end
            end
        end
        // A bad reply or an expired timer either resends or gives up on the link.
        if (fault) begin
            if (cur.tries < retry_q) begin
                nxt.tries         = cur.tries + 4'd1;
                nxt.ticks         = '0;
                r.send_request    = 1'b1;
                r.request_address = addr_q[cur.slave];
            end else begin
                nxt.phase     = rrpm_pkg::PHASE_CODE_FAIL;
                r.link_failed = 1'b1;
            end
        end
        r.phase_now = nxt.phase;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        rrpm_pkg::result_t got;
        rrpm_pkg::result_t want;
        poll_state_t       nxt;
        if (!rst_n) begin
            st        <= '{rrpm_pkg::PHASE_CODE_IDLE, 2'd0, 4'd0, 16'd0};
            timeout_q <= 16'd100;
            retry_q   <= 4'd3;
            addr_q[0] <= 8'd0;
            addr_q[1] <= 8'd1;
            addr_q[2] <= 8'd2;
            addr_q[3] <= 8'd3;
            expected_q.delete();
            outstanding = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_q.size() == 0) begin
                    errors++;
                    $error("result beat %h arrived with nothing expected", m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got.send_request !== want.send_request) begin
                        errors++;
                        $error("send_request: expected %0d, actual %0d",
                               want.send_request, got.send_request);
                    end
                    if (got.request_address !== want.request_address) begin
                        errors++;
                        $error("request_address: expected %0d, actual %0d",
                               want.request_address, got.request_address);
                    end
                    if (got.reply_taken !== want.reply_taken) begin
                        errors++;
                        $error("reply_taken: expected %0d, actual %0d",
                               want.reply_taken, got.reply_taken);
                    end
                    if (got.reply_slave !== want.reply_slave) begin
                        errors++;
                        $error("reply_slave: expected %0d, actual %0d",
                               want.reply_slave, got.reply_slave);
                    end
                    if (got.cycle_done !== want.cycle_done) begin
                        errors++;
                        $error("cycle_done: expected %0d, actual %0d",
                               want.cycle_done, got.cycle_done);
                    end
                    if (got.link_failed !== want.link_failed) begin
                        errors++;
                        $error("link_failed: expected %0d, actual %0d",
                               want.link_failed, got.link_failed);
                    end
                    if (got.phase_now !== want.phase_now) begin
                        errors++;
                        $error("phase_now: expected %0d, actual %0d",
                               want.phase_now, got.phase_now);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(poll_event(s_tdata[1:0], s_tdata[2], st, nxt));
                st <= nxt;
            end
            if (cfg_we) begin
                case (cfg_index)
                    rrpm_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
                    rrpm_pkg::REG_RETRY:   retry_q   <= cfg_data[3:0];
                    rrpm_pkg::REG_ADDR0:   addr_q[0] <= cfg_data[7:0];
                    rrpm_pkg::REG_ADDR1:   addr_q[1] <= cfg_data[7:0];
                    rrpm_pkg::REG_ADDR2:   addr_q[2] <= cfg_data[7:0];
                    rrpm_pkg::REG_ADDR3:   addr_q[3] <= cfg_data[7:0];
                    default:     ;
                endcase
            end
            outstanding = expected_q.size();
        end
    end

endmodule

[tb/tb.sv]
// Top of the testbench for round_robin_poll_master_retry_core: clock, reset, event
// stimulus, register setup, idling on both channels and the final verdict.
// Depends on rrpm_pkg, the block itself and poll_master_checker.
`timescale 1ns / 1ps
module tb;

    // Command code 3 has no meaning and must be ignored by the master.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 500_000;
    localparam int         RANDOM_ITEMS = 1550;
    localparam int         NUM_PHASES   = 12;
    localparam int         SOAK_TICKS   = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [1:0] command, [2] reply_ok, [7:3] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [0] send_request, [8:1] request_address,
                                   // [9] reply_taken, [11:10] reply_slave,
                                   // [12] cycle_done, [13] link_failed,
                                   // [15:14] phase_now
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int          pending;
    int          fail_count;
    logic [1:0]  phase_hint;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;

    round_robin_poll_master_retry_core #(
        .NUM_SLAVES (4)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    poll_master_checker #(
        .NUM_SLAVES (4)
    ) poll_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .phase_hint (phase_hint),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** round_robin_poll_master_retry_core: FAILED **");
            $finish;
        end
    end

    // Result receiver: stalls at random according to the current idling mode.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 63; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 63; end
            IDLE_BOTH:     begin gap_pct = 27; stall_pct = 27; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Presents one event beat, after an optional random gap, and returns at the
    // edge where it is accepted. tvalid stays high if the next beat follows at once.
    task automatic send_event(input logic [1:0] cmd, input logic ok);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ok, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops the event stream and waits until every result beat has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] timeout, input logic [3:0] retries,
                               input logic [7:0] a0, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [7:0] a3);
        write_reg(rrpm_pkg::REG_TIMEOUT, timeout);
        write_reg(rrpm_pkg::REG_RETRY, {12'd0, retries});
        write_reg(rrpm_pkg::REG_ADDR0, {8'd0, a0});
        write_reg(rrpm_pkg::REG_ADDR1, {8'd0, a1});
        write_reg(rrpm_pkg::REG_ADDR2, {8'd0, a2});
        write_reg(rrpm_pkg::REG_ADDR3, {8'd0, a3});
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         counted;
        int         pick;
        logic [1:0] cmd;
        logic       ok;
        logic [1:0] hint;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration: events outside waiting,
        // a full cycle, retries running out, restarts from failed and waiting.
        set_idling(IDLE_BOTH);
        send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        send_event(rrpm_pkg::CMD_TICK, 1'b1);
        send_event(CMD_UNUSED, 1'b1);
        send_event(rrpm_pkg::CMD_START, 1'b0);
        repeat (4) send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        send_event(rrpm_pkg::CMD_START, 1'b1);
        repeat (4) send_event(rrpm_pkg::CMD_REPLY, 1'b0);
        send_event(rrpm_pkg::CMD_TICK, 1'b0);
        send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        send_event(CMD_UNUSED, 1'b0);
        send_event(rrpm_pkg::CMD_START, 1'b0);
        send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        send_event(rrpm_pkg::CMD_START, 1'b0);
        send_event(CMD_UNUSED, 1'b1);
        drain();

        // A timeout of one with no retries: the second tick kills the link.
        load_config(16'd1, 4'd0, 8'hFF, 8'h00, 8'hAA, 8'h55);
        send_event(rrpm_pkg::CMD_START, 1'b1);
        send_event(rrpm_pkg::CMD_TICK, 1'b0);
        send_event(rrpm_pkg::CMD_TICK, 1'b1);
        drain();

        // A zero timeout expires on the very first tick and resends.
        load_config(16'd0, 4'd15, 8'h55, 8'hAA, 8'h00, 8'hFF);
        send_event(rrpm_pkg::CMD_START, 1'b0);
        send_event(rrpm_pkg::CMD_TICK, 1'b0);
        send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        drain();

        // Long wait: with the largest timeout a run of ticks never expires. Lowering
        // the timeout to the count already reached makes the next tick expire.
        set_idling(IDLE_NONE);
        load_config(16'hFFFF, 4'd1, 8'h12, 8'h34, 8'h56, 8'h78);
        send_event(rrpm_pkg::CMD_START, 1'b0);
        repeat (SOAK_TICKS) send_event(rrpm_pkg::CMD_TICK, 1'b0);
        drain();
        load_config(16'(SOAK_TICKS), 4'd1, 8'h12, 8'h34, 8'h56, 8'h78);
        send_event(rrpm_pkg::CMD_TICK, 1'b1);
        send_event(rrpm_pkg::CMD_REPLY, 1'b1);
        drain();

        // Random part: mostly well-formed polling with random timing of ticks and
        // replies, some bad replies, stray restarts and the unused command code.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: load_config(16'd1, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00);
                1: load_config(16'hFFFF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: load_config(16'd2, 4'd15, 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom));
                3: load_config(16'd100, 4'd3, 8'd0, 8'd1, 8'd2, 8'd3);
                9: load_config(16'($urandom_range(300, 9)), 4'($urandom_range(15)),
                               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                default: load_config(16'($urandom_range(8, 1)), 4'($urandom_range(15)),
                                     8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom));
            endcase
            set_idling(idle_mode_t'(p % 4));
            counted = 0;
            while (counted < RANDOM_ITEMS / NUM_PHASES)
            begin
                // The hint lags by one beat, which is close enough for steering.
                hint = phase_hint;
                pick = $urandom_range(99);
                if (hint != rrpm_pkg::PHASE_CODE_WAIT && $urandom_range(99) < 75)
                    cmd = rrpm_pkg::CMD_START;
                else if (pick < 52)
                    cmd = rrpm_pkg::CMD_TICK;
                else if (pick < 92)
                    cmd = rrpm_pkg::CMD_REPLY;
                else if (pick < 96)
                    cmd = rrpm_pkg::CMD_START;
                else
                    cmd = CMD_UNUSED;
                if (cmd == rrpm_pkg::CMD_REPLY)
                    ok = ($urandom_range(99) < 78);
                else
                    ok = 1'($urandom_range(1));
                if (cmd == rrpm_pkg::CMD_START || hint == rrpm_pkg::PHASE_CODE_WAIT)
                    counted++;
                send_event(cmd, ok);
            end
            drain();
        end

        // Give a stray extra result beat a chance to show up before the verdict.
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("** round_robin_poll_master_retry_core: PASSED **");
        else
            $display("** round_robin_poll_master_retry_core: FAILED **");
        $finish;
    end

endmodule
